// ===== src/ufmt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufmt_pkg
// Shared types and constants of the UDP flow meter table.
// ----------------------------------------------------------------------------
package ufmt_pkg;

  localparam int FLOW_ENTRIES_DEF = 1024;

  localparam logic [31:0] SAMPLE_RESET = 32'd65536;

  // service port list
  localparam logic [15:0] SVC_LOW_LIMIT = 16'd1024;
  localparam logic [15:0] SVC_PORT_A    = 16'd4789;
  localparam logic [15:0] SVC_PORT_B    = 16'd8472;
  localparam logic [15:0] SVC_PORT_C    = 16'd51820;

  // register map (word index)
  localparam logic REG_SAMPLE_THR = 1'b0;

  // flow key: two addresses, two ports and the pid
  localparam int KEY_W   = 128;
  localparam int STAMP_W = 64;

  typedef struct packed {
    logic [31:0] caddr;
    logic [31:0] saddr;
    logic [15:0] cport;
    logic [15:0] sport;
    logic [31:0] pid;
  } flow_key_t;

  // classified request from front to back
  typedef struct packed {
    logic        send;
    logic        server;
    flow_key_t   key;
    logic [15:0] len;
    logic [63:0] now;
  } cmd_t;

  typedef struct packed {
    logic        report_kind;
    logic        local_role;
    logic        traffic_dir;
    flow_key_t   key;
    logic [15:0] reported_len;
    logic [63:0] sent_total;
    logic [63:0] recv_total;
    logic [63:0] flow_age;
  } res_t;

  // per-entry counters held in the data memory
  typedef struct packed {
    logic [63:0] sent;
    logic [63:0] recv;
    logic [63:0] first;
    logic [63:0] flushed;
  } cnt_t;

endpackage

`default_nettype wire

// ===== src/ufmt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufmt_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ufmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/ufmt_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufmt_fifo
// Small register queue with full/empty flags.
// ----------------------------------------------------------------------------
module ufmt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rptr_r];
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== src/ufmt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufmt_front
// Filters packet events, decides the local role, normalizes the key and
// queues the request for the table engine.
// ----------------------------------------------------------------------------
module ufmt_front
  import ufmt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic        req_type,
  input  wire logic [31:0] local_addr,
  input  wire logic [31:0] remote_addr,
  input  wire logic [15:0] local_port,
  input  wire logic [15:0] remote_port,
  input  wire logic [31:0] process_id,
  input  wire logic [15:0] pkt_len,
  input  wire logic [63:0] tick_time,
  input  wire logic        cmd_pop,
  output cmd_t             cmd_data,
  output logic             cmd_empty
);

  logic dropped, lsvc, rsvc, server, q_wr;
  cmd_t cmd;

  function automatic logic is_svc(input logic [15:0] p);
    return (p < SVC_LOW_LIMIT) || (p == SVC_PORT_A) || (p == SVC_PORT_B) ||
           (p == SVC_PORT_C);
  endfunction

  assign lsvc    = is_svc(local_port);
  assign rsvc    = is_svc(remote_port);
  assign dropped = (local_addr == '0) || (!req_type && (pkt_len == '0));

  always_comb begin
    if (req_type) begin
      if (rsvc)      server = 1'b0;
      else if (lsvc) server = 1'b1;
      else           server = !(local_port > remote_port);
    end else begin
      if (lsvc)      server = 1'b1;
      else if (rsvc) server = 1'b0;
      else           server = !(remote_port > local_port);
    end
  end

  always_comb begin
    cmd.send   = req_type;
    cmd.server = server;
    cmd.len    = pkt_len;
    cmd.now    = tick_time;
    cmd.key.pid = process_id;
    if (server) begin
      cmd.key.caddr = remote_addr;
      cmd.key.saddr = local_addr;
      cmd.key.cport = remote_port;
      cmd.key.sport = local_port;
    end else begin
      cmd.key.caddr = local_addr;
      cmd.key.saddr = remote_addr;
      cmd.key.cport = local_port;
      cmd.key.sport = remote_port;
    end
  end

  assign q_wr = push && !full && !dropped;

  ufmt_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (q_wr),
    .wdata (cmd),
    .full  (full),
    .rd_en (cmd_pop),
    .rdata (cmd_data),
    .empty (cmd_empty)
  );

endmodule

`default_nettype wire

// ===== src/ufmt_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufmt_engine
// Flow table: scans the key memory, picks the hit, free or LRU entry,
// updates the counters and reports new flows and threshold crossings.
// ----------------------------------------------------------------------------
module ufmt_engine
  import ufmt_pkg::*;
#(
  parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [31:0] sample_thr,
  input  wire logic        cmd_empty,
  input  cmd_t             cmd_data,
  output logic             cmd_pop,
  input  wire logic        res_full,
  output logic             res_push,
  output res_t             res_data
);

  localparam int IDX_W = $clog2(FLOW_ENTRIES);
  localparam int FIL_W = IDX_W + 1;
  localparam int KR_W  = KEY_W + STAMP_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_READ = 7'b0000100,
    S_ADD  = 7'b0001000,
    S_TOT  = 7'b0010000,
    S_CMP  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t               state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [FIL_W-1:0]     fill_r, fill_nxt;
  logic [FIL_W-1:0]     issue_r, issue_nxt;
  logic [STAMP_W-1:0]   stamp_r, stamp_nxt;
  logic                 cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [STAMP_W-1:0]   best_stamp_r, best_stamp_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 hit_r, hit_nxt;
  logic [63:0]          sent_r, sent_nxt, recv_r, recv_nxt;
  logic [63:0]          first_r, first_nxt, flushed_r, flushed_nxt;
  logic [63:0]          total_r, total_nxt, age_r, age_nxt;

  logic [IDX_W-1:0]     kram_raddr, dram_raddr;
  logic [KR_W-1:0]      kram_rdata, kram_wdata;
  cnt_t                 dram_rdata, dram_wdata;
  logic                 mem_we;
  flow_key_t            key_rd;
  logic [STAMP_W-1:0]   stamp_rd;
  logic [63:0]          diff;
  logic                 report;
  logic                 full_tbl;

  assign key_rd   = kram_rdata[KR_W-1:STAMP_W];
  assign stamp_rd = kram_rdata[STAMP_W-1:0];
  assign full_tbl = (fill_r == FIL_W'(FLOW_ENTRIES));
  assign diff     = total_r - flushed_r;
  assign report   = !hit_r || (diff >= {32'd0, sample_thr});

  assign kram_wdata = {cmd_r.key, stamp_r};
  assign dram_wdata = '{sent: sent_r, recv: recv_r, first: first_r,
                        flushed: report ? total_r : flushed_r};
  assign dram_raddr = idx_r;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    fill_nxt       = fill_r;
    issue_nxt      = issue_r;
    stamp_nxt      = stamp_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    best_idx_nxt   = best_idx_r;
    best_stamp_nxt = best_stamp_r;
    idx_nxt        = idx_r;
    hit_nxt        = hit_r;
    sent_nxt       = sent_r;
    recv_nxt       = recv_r;
    first_nxt      = first_r;
    flushed_nxt    = flushed_r;
    total_nxt      = total_r;
    age_nxt        = age_r;
    kram_raddr     = issue_r[IDX_W-1:0];
    mem_we         = 1'b0;
    cmd_pop        = 1'b0;
    res_push       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop   = 1'b1;
          cmd_nxt   = cmd_data;
          issue_nxt = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cmp_vld_r && (key_rd == cmd_r.key)) begin
          hit_nxt   = 1'b1;
          idx_nxt   = cmp_idx_r;
          state_nxt = S_READ;
        end else if (!cmp_vld_r && (issue_r == fill_r)) begin
          hit_nxt   = 1'b0;
          idx_nxt   = full_tbl ? best_idx_r : fill_r[IDX_W-1:0];
          state_nxt = S_READ;
        end else begin
          if (cmp_vld_r && ((cmp_idx_r == '0) || (stamp_rd < best_stamp_r))) begin
            best_idx_nxt   = cmp_idx_r;
            best_stamp_nxt = stamp_rd;
          end
          if (issue_r < fill_r) begin
            cmp_vld_nxt = 1'b1;
            cmp_idx_nxt = issue_r[IDX_W-1:0];
            issue_nxt   = issue_r + 1'b1;
          end
        end
      end
      S_READ: begin
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if (hit_r) begin
          sent_nxt    = cmd_r.send ? dram_rdata.sent + 64'(cmd_r.len) : dram_rdata.sent;
          recv_nxt    = cmd_r.send ? dram_rdata.recv : dram_rdata.recv + 64'(cmd_r.len);
          first_nxt   = dram_rdata.first;
          flushed_nxt = dram_rdata.flushed;
          age_nxt     = (dram_rdata.first != '0) ? cmd_r.now - dram_rdata.first : '0;
        end else begin
          sent_nxt    = cmd_r.send ? 64'(cmd_r.len) : '0;
          recv_nxt    = cmd_r.send ? '0 : 64'(cmd_r.len);
          first_nxt   = cmd_r.now;
          flushed_nxt = '0;
          age_nxt     = '0;
        end
        state_nxt = S_TOT;
      end
      S_TOT: begin
        total_nxt = sent_r + recv_r;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        mem_we    = 1'b1;
        stamp_nxt = stamp_r + 1'b1;
        if (!hit_r && !full_tbl) begin
          fill_nxt = fill_r + 1'b1;
        end
        state_nxt = report ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    res_data.report_kind  = hit_r;
    res_data.local_role   = cmd_r.server;
    res_data.traffic_dir  = cmd_r.send;
    res_data.key          = cmd_r.key;
    res_data.reported_len = cmd_r.len;
    res_data.sent_total   = sent_r;
    res_data.recv_total   = recv_r;
    res_data.flow_age     = age_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r    <= '0;
      stamp_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      stamp_r   <= stamp_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    issue_r      <= issue_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_stamp_r <= best_stamp_nxt;
    idx_r        <= idx_nxt;
    hit_r        <= hit_nxt;
    sent_r       <= sent_nxt;
    recv_r       <= recv_nxt;
    first_r      <= first_nxt;
    flushed_r    <= flushed_nxt;
    total_r      <= total_nxt;
    age_r        <= age_nxt;
  end

  // key + access stamp
  ufmt_ram #(
    .WIDTH (KR_W),
    .DEPTH (FLOW_ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx_r),
    .wdata (kram_wdata),
    .raddr (kram_raddr),
    .rdata (kram_rdata)
  );

  // byte counters, first-seen time, last reported total
  ufmt_ram #(
    .WIDTH ($bits(cnt_t)),
    .DEPTH (FLOW_ENTRIES)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx_r),
    .wdata (dram_wdata),
    .raddr (dram_raddr),
    .rdata (dram_rdata)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FIL_W'(FLOW_ENTRIES))
    else $error("fill count beyond table size");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (state_r == S_IDLE) && !cmd_empty)
    else $error("request taken while busy");

  a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full && (state_r == S_OUT))
    else $error("result pushed into full queue");

  a_write_then_done: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> (state_r == S_OUT) || (state_r == S_IDLE))
    else $error("table write not followed by report or idle");

endmodule

`default_nettype wire

// ===== src/udp_flow_meter_table_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udp_flow_meter_table_top
// Per-flow UDP byte metering with an LRU flow table and threshold reports.
// ----------------------------------------------------------------------------
// Flow: the engine takes one request from the queue and scans the key memory
//   one entry per cycle, stopping at a matching key or after the last filled
//   entry; it then reads the counters, adds the length, forms the total, writes
//   both memories and, when a report is due, waits for room in the result queue.
//   A new request is taken only after the previous one is done.
// Reset: rst_n (sync, low) empties both queues and the table (fill count 0);
//   the memories are not cleared, threshold returns to 65536.
// ----------------------------------------------------------------------------
module udp_flow_meter_table_top
  import ufmt_pkg::*;
#(
  parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request side
  input  wire logic        push,
  output logic             full,
  input  wire logic        in_req_type,
  input  wire logic [31:0] in_local_addr,
  input  wire logic [31:0] in_remote_addr,
  input  wire logic [15:0] in_local_port,
  input  wire logic [15:0] in_remote_port,
  input  wire logic [31:0] in_process_id,
  input  wire logic [15:0] in_pkt_len,
  input  wire logic [63:0] in_tick_time,
  // result side
  output logic             empty,
  input  wire logic        pop,
  output logic             out_report_kind,
  output logic             out_local_role,
  output logic             out_traffic_dir,
  output logic      [31:0] out_client_addr,
  output logic      [31:0] out_server_addr,
  output logic      [15:0] out_client_port,
  output logic      [15:0] out_server_port,
  output logic      [31:0] out_flow_pid,
  output logic      [15:0] out_reported_len,
  output logic      [63:0] out_sent_total,
  output logic      [63:0] out_recv_total,
  output logic      [63:0] out_flow_age,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [31:0] thr_r, thr_nxt;
  logic        cmd_empty, cmd_pop;
  cmd_t        cmd_data;
  logic        res_full, res_push;
  res_t        res_wdata, res_rdata;

  // Register file: only the sample threshold, at word 0. Other words read 0
  // and ignore writes.
  assign pready = 1'b1;

  always_comb begin
    thr_nxt = thr_r;
    if (psel && penable && pwrite && (paddr[2] == REG_SAMPLE_THR)) begin
      thr_nxt = pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_SAMPLE_THR) ? thr_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= SAMPLE_RESET;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  // Front: drops unbound / empty receives, classifies, queues the request.
  ufmt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .req_type    (in_req_type),
    .local_addr  (in_local_addr),
    .remote_addr (in_remote_addr),
    .local_port  (in_local_port),
    .remote_port (in_remote_port),
    .process_id  (in_process_id),
    .pkt_len     (in_pkt_len),
    .tick_time   (in_tick_time),
    .cmd_pop     (cmd_pop),
    .cmd_data    (cmd_data),
    .cmd_empty   (cmd_empty)
  );

  // Back: table lookup, LRU replacement, counter update, report decision.
  ufmt_engine #(
    .FLOW_ENTRIES (FLOW_ENTRIES)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .sample_thr (thr_r),
    .cmd_empty  (cmd_empty),
    .cmd_data   (cmd_data),
    .cmd_pop    (cmd_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_data   (res_wdata)
  );

  // Result queue decouples the engine from the consumer.
  ufmt_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .rd_en (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign out_report_kind  = res_rdata.report_kind;
  assign out_local_role   = res_rdata.local_role;
  assign out_traffic_dir  = res_rdata.traffic_dir;
  assign out_client_addr  = res_rdata.key.caddr;
  assign out_server_addr  = res_rdata.key.saddr;
  assign out_client_port  = res_rdata.key.cport;
  assign out_server_port  = res_rdata.key.sport;
  assign out_flow_pid     = res_rdata.key.pid;
  assign out_reported_len = res_rdata.reported_len;
  assign out_sent_total   = res_rdata.sent_total;
  assign out_recv_total   = res_rdata.recv_total;
  assign out_flow_age     = res_rdata.flow_age;

endmodule

`default_nettype wire
